// ===== rtl/ngm_pkg.sv =====
// Shared types, constants and the CORDIC angle table for normal_gravity_model.
// No dependencies.
`default_nettype none
package ngm_pkg;

  localparam int MUL_W    = 36;  // signed operand width of the serial multiplier
  localparam int RES_W    = 44;  // signed width of a rounded product
  localparam int DIGIT_W  = 4;
  localparam int DIGITS   = MUL_W / DIGIT_W;
  localparam int ANG_W    = 34;  // CORDIC x, y, z width
  localparam int NUM_W    = 58;  // |h| << 30
  localparam int DIV_W    = 32;

  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [MUL_W-1:0] Q30_ONE     = 36'sd1073741824;
  localparam logic signed [MUL_W-1:0] Q_LIMIT     = 36'sd536870912;
  localparam logic signed [RES_W-1:0] AB_LIMIT    = 44'sd4294967296;

  localparam logic [30:0] RST_EQ_GRAVITY   = 31'd164086655;
  localparam logic [30:0] RST_GRAV_FLAT    = 31'd22773807;
  localparam logic [30:0] RST_ELL_FLAT     = 31'd14400212;
  localparam logic [30:0] RST_CENTRIFUGAL  = 31'd14816718;
  localparam logic signed [31:0] RST_HARMONIC = 32'sd25013;
  localparam logic [30:0] RST_SEMIMAJOR    = 31'd637813700;
  localparam logic signed [31:0] RST_HELD_LAT = 32'sd843314857;

  typedef enum logic [2:0] {
    REG_EQ_GRAVITY   = 3'd0,
    REG_GRAV_FLAT    = 3'd1,
    REG_ELL_FLAT     = 3'd2,
    REG_CENTRIFUGAL  = 3'd3,
    REG_HARMONIC     = 3'd4,
    REG_SEMIMAJOR    = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    SH29 = 2'd0,
    SH30 = 2'd1,
    SH32 = 2'd2
  } shift_t;

  typedef enum logic [3:0] {
    OP_SIN2    = 4'd0,
    OP_COS_SQ  = 4'd1,
    OP_SIN_SQ  = 4'd2,
    OP_SIN2_SQ = 4'd3,
    OP_GE_FG   = 4'd4,
    OP_T_SIN2  = 4'd5,
    OP_T_Q     = 4'd6,
    OP_FG_S2   = 4'd7,
    OP_F4_SQ   = 4'd8,
    OP_F_COS2  = 4'd9,
    OP_C_Q     = 4'd10,
    OP_Q_Q     = 4'd11,
    OP_A_B     = 4'd12,
    OP_GE_AB   = 4'd13
  } op_t;

  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [5:0] i);
    logic signed [ANG_W-1:0] v;
    case (i)
      6'd0:  v = 34'sd843314856;
      6'd1:  v = 34'sd497837829;
      6'd2:  v = 34'sd263043836;
      6'd3:  v = 34'sd133525158;
      6'd4:  v = 34'sd67021686;
      6'd5:  v = 34'sd33543515;
      6'd6:  v = 34'sd16775850;
      6'd7:  v = 34'sd8388437;
      6'd8:  v = 34'sd4194282;
      6'd9:  v = 34'sd2097149;
      6'd10: v = 34'sd1048575;
      default: begin
        if (i <= 6'd30) v = 34'sd1 <<< (6'd30 - i);
        else v = '0;
      end
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [RES_W:0] v);
    logic signed [31:0] r;
    if (v > 45'sd2147483647) r = 32'sh7fffffff;
    else if (v < -45'sd2147483648) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/normal_gravity_model.sv =====
// Top level of normal_gravity_model: position select, iterative CORDIC,
// bit-serial divider and a sequenced digit-serial multiplier (ngm_mul, ngm_pkg).
//
//   port group  dir  content
//   in_*        in   tuser: own valid, hybrid valid; tdata: positions
//   out_*       out  tdata: north_gravity, up_gravity
//   cfg_*       in   register writes, index 0..5
//
// One item goes from accept to the next accept through a load, the divider (58
// steps and the done check, CORDIC alongside), a finish step, 14 products on the
// shared multiplier, and the load of the output register.
// Reset is synchronous and needs no sweep.
// in_tready is low while an item is in work; a stalled output holds only the
// final load, the next item can already be taken when the result register frees.
`default_nettype none
module normal_gravity_model #(
  parameter int CORDIC_STEPS = 30
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [1:0]   in_tuser,  // [0] own_position_valid, [1] hybrid_position_valid
  input  wire logic [119:0] in_tdata,  // own_latitude, own_height, hybrid_latitude,
                                       // hybrid_height
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata, // north_gravity, up_gravity
  input  wire logic         cfg_wr_en,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata
);

  localparam int CW  = $clog2(CORDIC_STEPS + 1);
  localparam int AW  = ngm_pkg::ANG_W;
  localparam int MW  = ngm_pkg::MUL_W;
  localparam int RW  = ngm_pkg::RES_W;
  localparam int NW  = ngm_pkg::NUM_W;
  localparam int DW  = ngm_pkg::DIV_W;
  localparam int DCW = $clog2(NW + 1);

  typedef enum logic [2:0] {S_IDLE, S_CALC, S_FIN, S_MUL_START, S_MUL_WAIT, S_OUT} state_t;

  state_t state_r;

  // configuration
  logic [30:0]        eq_gravity_r, grav_flat_r, ell_flat_r, centrifugal_r, semimajor_r;
  logic signed [31:0] harmonic_r;

  logic signed [31:0] held_lat_r;
  logic signed [27:0] held_h_r;

  // CORDIC
  logic signed [AW-1:0] x_r, y_r, z_r;
  logic                 cneg_r;
  logic [CW-1:0]        iter_r;

  // divider
  logic [NW-1:0]  num_r, quo_r;
  logic [DW-1:0]  rem_r, d_r;
  logic [DCW-1:0] dcnt_r;
  logic           hneg_r, dbad_r;

  // products
  ngm_pkg::op_t        op_r;
  logic signed [MW-1:0] s_r, c_r, q_r, sin2_r, cc_r, s2_r, cos2_r, sin2sq_r, t_r;
  logic signed [MW-1:0] a1_r, amul_r, cmul_r, b1_r, bmul_r, ab_r;
  logic signed [31:0]   north_r, up_r;
  logic                 out_tvalid_r;
  logic [63:0]          out_tdata_r;

  logic                  accept;
  logic signed [31:0]    sel_lat;
  logic signed [27:0]    sel_h;
  logic signed [AW-1:0]  lat_ext;
  logic signed [AW-1:0]  dx, dy, ang;
  logic signed [33:0]    denom;
  logic [DW:0]           trial;
  logic [29:0]           qmag;
  logic                  mstart;
  logic signed [MW-1:0]  ma, mb;
  ngm_pkg::shift_t       msh;
  logic                  mdone;
  logic signed [RW-1:0]  mres;
  logic signed [RW:0]    mres_neg;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    sel_lat = held_lat_r;
    sel_h   = held_h_r;
    if (in_tuser[0]) begin
      sel_lat = $signed(in_tdata[31:0]);
      sel_h   = $signed(in_tdata[59:32]);
    end else if (in_tuser[1]) begin
      sel_lat = $signed(in_tdata[91:60]);
      sel_h   = $signed(in_tdata[119:92]);
    end
  end

  assign lat_ext = AW'(sel_lat);
  assign denom   = $signed({3'b000, semimajor_r}) + 34'(sel_h);

  assign dx  = x_r >>> iter_r;
  assign dy  = y_r >>> iter_r;
  assign ang = ngm_pkg::atan_entry(6'(iter_r));

  assign trial = {rem_r, num_r[NW-1]} - {1'b0, d_r};
  assign qmag  = (quo_r > NW'(30'd536870912)) ? 30'd536870912 : quo_r[29:0];

  assign mres_neg = -$signed({mres[RW-1], mres});

  always_comb begin
    ma  = s_r;
    mb  = c_r;
    msh = ngm_pkg::SH30;
    case (op_r)
      ngm_pkg::OP_SIN2:    begin ma = s_r;      mb = c_r;      msh = ngm_pkg::SH29; end
      ngm_pkg::OP_COS_SQ:  begin ma = c_r;      mb = c_r;      end
      ngm_pkg::OP_SIN_SQ:  begin ma = s_r;      mb = s_r;      end
      ngm_pkg::OP_SIN2_SQ: begin ma = sin2_r;   mb = sin2_r;   end
      ngm_pkg::OP_GE_FG:   begin
        ma = MW'(eq_gravity_r); mb = MW'(grav_flat_r); msh = ngm_pkg::SH32;
      end
      ngm_pkg::OP_T_SIN2:  begin ma = t_r;      mb = sin2_r;   end
      ngm_pkg::OP_T_Q:     begin ma = t_r;      mb = q_r;      end
      ngm_pkg::OP_FG_S2:   begin ma = MW'(grav_flat_r); mb = s2_r;   msh = ngm_pkg::SH32; end
      ngm_pkg::OP_F4_SQ:   begin ma = MW'(harmonic_r);  mb = sin2sq_r; msh = ngm_pkg::SH32; end
      ngm_pkg::OP_F_COS2:  begin ma = MW'(ell_flat_r);  mb = cos2_r; msh = ngm_pkg::SH32; end
      ngm_pkg::OP_C_Q:     begin ma = cmul_r;   mb = q_r;      end
      ngm_pkg::OP_Q_Q:     begin ma = q_r;      mb = q_r;      end
      ngm_pkg::OP_A_B:     begin ma = amul_r;   mb = bmul_r;   end
      ngm_pkg::OP_GE_AB:   begin ma = MW'(eq_gravity_r); mb = ab_r; end
      default: ;
    endcase
  end

  assign mstart = (state_r == S_MUL_START);

  ngm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mstart),
    .a     (ma),
    .b     (mb),
    .sh    (msh),
    .done  (mdone),
    .res   (mres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_tvalid_r  <= 1'b0;
      eq_gravity_r  <= ngm_pkg::RST_EQ_GRAVITY;
      grav_flat_r   <= ngm_pkg::RST_GRAV_FLAT;
      ell_flat_r    <= ngm_pkg::RST_ELL_FLAT;
      centrifugal_r <= ngm_pkg::RST_CENTRIFUGAL;
      harmonic_r    <= ngm_pkg::RST_HARMONIC;
      semimajor_r   <= ngm_pkg::RST_SEMIMAJOR;
      held_lat_r    <= ngm_pkg::RST_HELD_LAT;
      held_h_r      <= '0;
      op_r          <= ngm_pkg::OP_SIN2;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          ngm_pkg::REG_EQ_GRAVITY:  eq_gravity_r  <= cfg_wdata[30:0];
          ngm_pkg::REG_GRAV_FLAT:   grav_flat_r   <= cfg_wdata[30:0];
          ngm_pkg::REG_ELL_FLAT:    ell_flat_r    <= cfg_wdata[30:0];
          ngm_pkg::REG_CENTRIFUGAL: centrifugal_r <= cfg_wdata[30:0];
          ngm_pkg::REG_HARMONIC:    harmonic_r    <= $signed(cfg_wdata);
          ngm_pkg::REG_SEMIMAJOR:   semimajor_r   <= cfg_wdata[30:0];
          default: ;
        endcase
      end

      // S_OUT refills the register itself when the beat leaves
      if (out_tvalid_r && out_tready && state_r != S_OUT) out_tvalid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            held_lat_r <= sel_lat;
            held_h_r   <= sel_h;
            // fold latitude into [-pi/2, pi/2], cos sign flips
            x_r <= ngm_pkg::CORDIC_GAIN;
            y_r <= '0;
            if (lat_ext > ngm_pkg::HALF_PI_Q30) begin
              z_r    <= ngm_pkg::PI_Q30 - lat_ext;
              cneg_r <= 1'b1;
            end else if (lat_ext < -ngm_pkg::HALF_PI_Q30) begin
              z_r    <= -ngm_pkg::PI_Q30 - lat_ext;
              cneg_r <= 1'b1;
            end else begin
              z_r    <= lat_ext;
              cneg_r <= 1'b0;
            end
            iter_r <= '0;
            hneg_r <= sel_h[27];
            num_r  <= {(sel_h[27] ? 28'(-sel_h) : 28'(sel_h)), 30'd0};
            dbad_r <= (denom <= 34'sd0);
            d_r    <= denom[DW-1:0];
            rem_r  <= '0;
            quo_r  <= '0;
            dcnt_r <= '0;
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          if (iter_r != CW'(CORDIC_STEPS)) begin
            if (!z_r[AW-1]) begin
              x_r <= x_r - dy; y_r <= y_r + dx; z_r <= z_r - ang;
            end else begin
              x_r <= x_r + dy; y_r <= y_r - dx; z_r <= z_r + ang;
            end
            iter_r <= iter_r + CW'(1);
          end
          if (dcnt_r != DCW'(NW)) begin
            if (!trial[DW]) begin
              rem_r <= trial[DW-1:0];
              quo_r <= {quo_r[NW-2:0], 1'b1};
            end else begin
              rem_r <= {rem_r[DW-2:0], num_r[NW-1]};
              quo_r <= {quo_r[NW-2:0], 1'b0};
            end
            num_r  <= num_r << 1;
            dcnt_r <= dcnt_r + DCW'(1);
          end
          if (iter_r == CW'(CORDIC_STEPS) && dcnt_r == DCW'(NW)) state_r <= S_FIN;
        end
        S_FIN: begin
          s_r <= MW'(y_r);
          c_r <= cneg_r ? MW'(-x_r) : MW'(x_r);
          if (dbad_r) q_r <= -ngm_pkg::Q_LIMIT;
          else q_r <= hneg_r ? -MW'(qmag) : MW'(qmag);
          op_r    <= ngm_pkg::OP_SIN2;
          state_r <= S_MUL_START;
        end
        S_MUL_START: state_r <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (mdone) begin
            case (op_r)
              ngm_pkg::OP_SIN2:    sin2_r   <= MW'(mres);
              ngm_pkg::OP_COS_SQ:  cc_r     <= MW'(mres);
              ngm_pkg::OP_SIN_SQ: begin
                s2_r   <= MW'(mres);
                cos2_r <= cc_r - MW'(mres);
              end
              ngm_pkg::OP_SIN2_SQ: sin2sq_r <= MW'(mres);
              ngm_pkg::OP_GE_FG:   t_r      <= MW'(mres);
              ngm_pkg::OP_T_SIN2:  t_r      <= MW'(mres);
              ngm_pkg::OP_T_Q:     north_r  <= ngm_pkg::sat32(mres_neg);
              ngm_pkg::OP_FG_S2:   a1_r     <= MW'(mres);
              ngm_pkg::OP_F4_SQ:   amul_r   <= ngm_pkg::Q30_ONE + a1_r - MW'(mres);
              ngm_pkg::OP_F_COS2:
                cmul_r <= ngm_pkg::Q30_ONE + MW'(mres)
                          + MW'((33'(centrifugal_r) + 33'd2) >> 2);
              ngm_pkg::OP_C_Q:     b1_r     <= MW'(mres);
              ngm_pkg::OP_Q_Q:
                bmul_r <= ngm_pkg::Q30_ONE - (b1_r <<< 1) + MW'(mres);
              ngm_pkg::OP_A_B: begin
                if (mres > ngm_pkg::AB_LIMIT) ab_r <= MW'(ngm_pkg::AB_LIMIT);
                else if (mres < -ngm_pkg::AB_LIMIT) ab_r <= MW'(-ngm_pkg::AB_LIMIT);
                else ab_r <= MW'(mres);
              end
              ngm_pkg::OP_GE_AB:   up_r     <= ngm_pkg::sat32(mres_neg);
              default: ;
            endcase
            if (op_r == ngm_pkg::OP_GE_AB) begin
              state_r <= S_OUT;
            end else begin
              op_r    <= ngm_pkg::op_t'(op_r + 4'd1);
              state_r <= S_MUL_START;
            end
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {up_r, north_r};
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire

// ===== rtl/ngm_mul.sv =====
// Digit-serial signed multiplier with round-half-up arithmetic right shift.
// Uses ngm_pkg for widths and the shift select type.
`default_nettype none
module ngm_mul (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic signed [ngm_pkg::MUL_W-1:0] a,
  input  wire logic signed [ngm_pkg::MUL_W-1:0] b,
  input  wire ngm_pkg::shift_t                 sh,
  output logic                                 done,
  output logic signed [ngm_pkg::RES_W-1:0]     res
);

  localparam int AW = 2 * ngm_pkg::MUL_W;
  localparam int PW = ngm_pkg::MUL_W + ngm_pkg::DIGIT_W;

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_SIGN, M_ROUND} mstate_t;

  mstate_t                         state_r;
  logic [ngm_pkg::MUL_W-1:0]       mag_a_r;
  logic [ngm_pkg::MUL_W-1:0]       b_r;
  logic [AW-1:0]                   acc_r;
  logic                            neg_r;
  logic [3:0]                      cnt_r;
  ngm_pkg::shift_t                 sh_r;
  logic                            done_r;
  logic signed [ngm_pkg::RES_W-1:0] res_r;

  logic [PW-1:0]                   part;
  logic signed [AW-1:0]            rsum;
  logic signed [AW-1:0]            rnd;

  // one 4-bit digit of b per cycle, msb first
  assign part = PW'(mag_a_r) * PW'(b_r[ngm_pkg::MUL_W-1 -: ngm_pkg::DIGIT_W]);

  always_comb begin
    case (sh_r)
      ngm_pkg::SH29: rnd = AW'(64'sd1 <<< 28);
      ngm_pkg::SH30: rnd = AW'(64'sd1 <<< 29);
      default:       rnd = AW'(64'sd1 <<< 31);
    endcase
  end

  assign rsum = $signed(acc_r) + rnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (start) begin
            mag_a_r <= a[ngm_pkg::MUL_W-1] ? ngm_pkg::MUL_W'(-a) : ngm_pkg::MUL_W'(a);
            b_r     <= b[ngm_pkg::MUL_W-1] ? ngm_pkg::MUL_W'(-b) : ngm_pkg::MUL_W'(b);
            neg_r   <= a[ngm_pkg::MUL_W-1] ^ b[ngm_pkg::MUL_W-1];
            sh_r    <= sh;
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= M_RUN;
          end
        end
        M_RUN: begin
          acc_r <= (acc_r << ngm_pkg::DIGIT_W) + AW'(part);
          b_r   <= b_r << ngm_pkg::DIGIT_W;
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'(ngm_pkg::DIGITS - 1)) state_r <= M_SIGN;
        end
        M_SIGN: begin
          if (neg_r) acc_r <= -acc_r;
          state_r <= M_ROUND;
        end
        M_ROUND: begin
          case (sh_r)
            ngm_pkg::SH29: res_r <= ngm_pkg::RES_W'(rsum >>> 29);
            ngm_pkg::SH30: res_r <= ngm_pkg::RES_W'(rsum >>> 30);
            default:       res_r <= ngm_pkg::RES_W'(rsum >>> 32);
          endcase
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

// ===== test/tb_normal_gravity_model.sv =====
// Self-checking testbench for normal_gravity_model: a stream driver and an
// output checker around a built-in normal gravity predictor.
// Depends on ngm_pkg (register index codes) and the block's RTL.
`default_nettype none
module tb_normal_gravity_model;

  localparam logic [2:0] REG_SPARE = 3'd6;  // unmapped index, must be ignored
  localparam longint ONE_Q30  = 64'sd1073741824;
  localparam longint HALF_PI  = 64'sd1686629713;
  localparam longint FULL_PI  = 64'sd3373259426;
  localparam longint XY_GAIN  = 64'sd652032874;
  localparam longint RATIO_LIM = 64'sd536870912;
  localparam longint PROD_LIM = 64'sd4294967296;
  localparam longint I32_MAX  = 64'sd2147483647;
  localparam longint I32_MIN  = -64'sd2147483648;
  localparam longint H_MAX    = 64'sd100000000;

  // laid out to match {in_tuser, in_tdata}
  typedef struct packed {
    logic [1:0]         valid;  // [0] own, [1] hybrid
    logic signed [27:0] hyb_h;
    logic signed [31:0] hyb_lat;
    logic signed [27:0] own_h;
    logic signed [31:0] own_lat;
  } update_t;

  // laid out to match out_tdata
  typedef struct packed {
    logic signed [31:0] up;
    logic signed [31:0] north;
  } gravity_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [1:0]   in_tuser = '0;
  logic [119:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic         cfg_wr_en = 1'b0;
  logic [2:0]   cfg_addr = '0;
  logic [31:0]  cfg_wdata = '0;

  normal_gravity_model u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and register copies
  longint ge_r = 164086655, fg_r = 22773807, f_r = 14400212, m_r = 14816718;
  longint f4q_r = 25013, a_r = 637813700;
  longint held_lat = 843314857, held_h = 0;

  update_t  pending_updates[$];
  gravity_t expected_gravity[$];
  int tx_idle = 0, rx_idle = 0;
  int n_checked = 0, n_errors = 0, n_sent = 0;
  bit hold_req = 0, hold_done = 0;
  int hold_left = 0;

  function automatic longint rnd_mul(longint a, longint b, int s);
    return (a * b + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint arc_step(int i);
    case (i)
      0: return 843314856;   1: return 497837829;   2: return 263043836;
      3: return 133525158;   4: return 67021686;    5: return 33543515;
      6: return 16775850;    7: return 8388437;     8: return 4194282;
      9: return 2097149;     10: return 1048575;
      default: return (i <= 30) ? (64'sd1 <<< (30 - i)) : 0;
    endcase
  endfunction

  function automatic gravity_t predict_gravity(update_t u);
    longint x, y, z, dx, dy, s, c, q, denom, sin2, cos2, s2, sin2sq;
    longint t, a_f, c_f, b_f, ab;
    bit flip;
    gravity_t g;
    if (u.valid[0]) begin
      held_lat = u.own_lat; held_h = u.own_h;
    end else if (u.valid[1]) begin
      held_lat = u.hyb_lat; held_h = u.hyb_h;
    end
    denom = a_r + held_h;
    if (denom <= 0) q = -RATIO_LIM;
    else q = clip((held_h * ONE_Q30) / denom, -RATIO_LIM, RATIO_LIM);
    // fold latitude into +-pi/2, cosine changes sign
    z = held_lat; flip = 0;
    if (z > HALF_PI) begin
      z = FULL_PI - z; flip = 1;
    end else if (z < -HALF_PI) begin
      z = -FULL_PI - z; flip = 1;
    end
    x = XY_GAIN; y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = x >>> i; dy = y >>> i;
      if (z >= 0) begin
        x -= dy; y += dx; z -= arc_step(i);
      end else begin
        x += dy; y -= dx; z += arc_step(i);
      end
    end
    s = y; c = flip ? -x : x;
    sin2 = rnd_mul(s, c, 29);
    cos2 = rnd_mul(c, c, 30) - rnd_mul(s, s, 30);
    s2 = rnd_mul(s, s, 30);
    sin2sq = rnd_mul(sin2, sin2, 30);
    t = rnd_mul(ge_r, fg_r, 32);
    t = rnd_mul(t, sin2, 30);
    t = rnd_mul(t, q, 30);
    g.north = 32'(clip(-t, I32_MIN, I32_MAX));
    a_f = ONE_Q30 + rnd_mul(fg_r, s2, 32) - rnd_mul(f4q_r, sin2sq, 32);
    c_f = ONE_Q30 + rnd_mul(f_r, cos2, 32) + rnd_mul(m_r, 1, 2);
    b_f = ONE_Q30 - 2 * rnd_mul(c_f, q, 30) + rnd_mul(q, q, 30);
    ab = clip(rnd_mul(a_f, b_f, 30), -PROD_LIM, PROD_LIM);
    g.up = 32'(clip(-rnd_mul(ge_r, ab, 30), I32_MIN, I32_MAX));
    return g;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_gravity.push_back(predict_gravity({in_tuser, in_tdata}));
        n_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_updates.size() > 0 && $urandom_range(99) >= tx_idle) begin
          {in_tuser, in_tdata} <= pending_updates.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result checker and receiver back-pressure
  always @(posedge clk) begin
    gravity_t want, got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_gravity.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_tdata);
          n_errors++;
        end else begin
          want = expected_gravity.pop_front();
          n_checked++;
          if (got.north !== want.north) begin
            $display("%0t: north exp %0d got %0d", $time, want.north, got.north);
            n_errors++;
          end
          if (got.up !== want.up) begin
            $display("%0t: up exp %0d got %0d", $time, want.up, got.up);
            n_errors++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= 2000;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  function automatic logic signed [31:0] pick_lat();
    case ($urandom_range(5))
      0: return 32'(HALF_PI);
      1: return 32'(-HALF_PI);
      2: return 32'($urandom_range(2000) - 1000);
      default: return 32'(longint'($urandom_range(32'd3373259426, 0)) - HALF_PI);
    endcase
  endfunction

  function automatic logic signed [27:0] pick_height();
    case ($urandom_range(7))
      0: return 28'(H_MAX);
      1: return 28'(-H_MAX);
      2, 3: return 28'(longint'($urandom_range(200000000, 0)) - H_MAX);
      default: return 28'(longint'($urandom_range(2000000, 0)) - 64'sd1000000);
    endcase
  endfunction

  function automatic update_t random_update();
    update_t u;
    u.valid = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'b01 | 2'($urandom_range(1));
    u.own_lat = pick_lat(); u.own_h = pick_height();
    u.hyb_lat = pick_lat(); u.hyb_h = pick_height();
    return u;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1; cfg_addr <= idx; cfg_wdata <= v;
    case (idx)
      ngm_pkg::REG_EQ_GRAVITY:  ge_r = v[30:0];
      ngm_pkg::REG_GRAV_FLAT:   fg_r = v[30:0];
      ngm_pkg::REG_ELL_FLAT:    f_r = v[30:0];
      ngm_pkg::REG_CENTRIFUGAL: m_r = v[30:0];
      ngm_pkg::REG_HARMONIC:    f4q_r = longint'(signed'(v));
      ngm_pkg::REG_SEMIMAJOR:   a_r = v[30:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] ge, fg, f, m, f4q, a);
    write_reg(ngm_pkg::REG_EQ_GRAVITY, ge);
    write_reg(ngm_pkg::REG_GRAV_FLAT, fg);
    write_reg(ngm_pkg::REG_ELL_FLAT, f);
    write_reg(ngm_pkg::REG_CENTRIFUGAL, m);
    write_reg(ngm_pkg::REG_HARMONIC, f4q);
    write_reg(ngm_pkg::REG_SEMIMAJOR, a);
  endtask

  // wait until every result is in, then let the block settle
  task automatic drain();
    while (pending_updates.size() > 0 || expected_gravity.size() > 0 || in_tvalid)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic queue_update(logic [1:0] vld, longint lat, longint h);
    update_t u;
    u.valid = vld;
    u.own_lat = 32'(lat); u.own_h = 28'(h);
    u.hyb_lat = 32'(-lat); u.hyb_h = 28'(-h);
    pending_updates.push_back(u);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // directed: flag combinations, field extremes, latitude fold-over
    queue_update(2'b00, 0, 0);
    queue_update(2'b01, HALF_PI, H_MAX);
    queue_update(2'b01, -HALF_PI, -H_MAX);
    queue_update(2'b10, HALF_PI, H_MAX);
    queue_update(2'b11, 0, 0);
    queue_update(2'b00, 5, 5);
    queue_update(2'b01, 64'sd2147483647, 1000);
    queue_update(2'b01, -64'sd2147483648, -1000);
    queue_update(2'b10, 64'sd2000000000, 12345);
    queue_update(2'b01, 1, -1);
    queue_update(2'b01, -1, 1);
    queue_update(2'b10, 843314857, -H_MAX);
    drain();
    write_all(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'h7fff_ffff, 32'hffff_ffff);
    queue_update(2'b01, HALF_PI, H_MAX);
    queue_update(2'b01, 500000000, -H_MAX);
    drain();
    write_all(0, 0, 0, 0, 32'h8000_0000, 1);
    queue_update(2'b01, HALF_PI, -H_MAX);  // a+h not positive
    queue_update(2'b01, 700000000, H_MAX);  // ratio saturates
    queue_update(2'b10, -HALF_PI, 0);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_all(164086655, 22773807, 14400212, 14816718, 25013, 637813700);
        1: write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom | 1);
        2: write_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                     32'h8000_0000, 32'h7fff_ffff);
        3: write_all(0, 0, 0, 0, 32'h7fff_ffff, 1);
        4: begin
          write_all(164086655, 22773807, 14400212, 14816718, -25013, 50000000);
          write_reg(REG_SPARE, 32'h1234_5678);
        end
        default: write_all($urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom_range(32'h7fff_ffff, 1));
      endcase
      case (ph % 3)
        0: begin tx_idle = 25; rx_idle = 72; end
        1: begin tx_idle = 72; rx_idle = 25; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      for (int k = 0; k < 305; k++) pending_updates.push_back(random_update());
      if (ph == 2) hold_req = 1;
      drain();
    end
    $display("covered %0d updates, %0d results checked over 9 register settings",
             n_sent, n_checked);
    if (n_errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #40000000;
    $display("timeout with %0d results outstanding", expected_gravity.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/ngm_pkg.sv
rtl/ngm_mul.sv
rtl/normal_gravity_model.sv
test/tb_normal_gravity_model.sv
